[rtl/core/symbol_language_tokenizer_macros.svh]
// Assertion helpers for the tokenizer.
`ifndef SYMBOL_LANGUAGE_TOKENIZER_MACROS_SVH
`define SYMBOL_LANGUAGE_TOKENIZER_MACROS_SVH

// Same-cycle implication.
`define SLT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed: same-cycle implication");

// Next-cycle implication.
`define SLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed: next-cycle implication");

`endif

[rtl/core/slt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

   // Text position counter wraps at this length.
   localparam int MAX_TEXT = 65536;
   localparam int POS_W    = $clog2(MAX_TEXT);

   localparam int LEN_W = 16;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // Result queue.
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // Token kinds.
   localparam logic [3:0] KIND_UNKNOWN = 4'd0;
   localparam logic [3:0] KIND_ATOM    = 4'd1;
   localparam logic [3:0] KIND_NUMBER  = 4'd2;
   localparam logic [3:0] KIND_CHAR    = 4'd3;
   localparam logic [3:0] KIND_STRING  = 4'd4;
   localparam logic [3:0] KIND_LBRACE  = 4'd5;
   localparam logic [3:0] KIND_RBRACE  = 4'd6;
   localparam logic [3:0] KIND_ARROW   = 4'd7;
   localparam logic [3:0] KIND_COMMENT = 4'd8;

   // Fault codes.
   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_UNTERM  = 2'd1;
   localparam logic [1:0] FAULT_BADCHAR = 2'd2;

   // Special code points.
   localparam logic [20:0] CP_NEWLINE  = 21'h0000A;
   localparam logic [20:0] CP_SPACE    = 21'h00020;
   localparam logic [20:0] CP_DQUOTE   = 21'h00022;
   localparam logic [20:0] CP_SQUOTE   = 21'h00027;
   localparam logic [20:0] CP_LBRACE   = 21'h0007B;
   localparam logic [20:0] CP_RBRACE   = 21'h0007D;
   localparam logic [20:0] CP_ARROW    = 21'h02190;
   localparam logic [20:0] CP_JOT      = 21'h0235D;
   localparam logic [20:0] CP_MATH_LO  = 21'h0002A;
   localparam logic [20:0] CP_MATH_HI  = 21'h0002F;
   localparam logic [20:0] CP_APL_LO   = 21'h02336;
   localparam logic [20:0] CP_APL_HI   = 21'h0237A;

   localparam int NUM_LISTED = 22;
   localparam logic [20:0] LISTED_SYMBOLS [NUM_LISTED] = '{
      21'h0007C, 21'h0007E, 21'h000AF, 21'h000D7, 21'h000F7, 21'h02218,
      21'h02223, 21'h0223C, 21'h02260, 21'h02264, 21'h02265, 21'h022C6,
      21'h02227, 21'h02228, 21'h02229, 21'h0222A, 21'h02308, 21'h0230A,
      21'h022A4, 21'h022A5, 21'h02282, 21'h02283
   };

   typedef enum logic [6:0] {
      MODE_IDLE       = 7'b0000001,
      MODE_ATOM       = 7'b0000010,
      MODE_NUMBER     = 7'b0000100,
      MODE_STRING     = 7'b0001000,
      MODE_CHAR_BODY  = 7'b0010000,
      MODE_CHAR_CLOSE = 7'b0100000,
      MODE_COMMENT    = 7'b1000000
   } mode_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        end_of_text;
   } req_type;

   typedef struct packed {
      logic [3:0]       token_kind;
      logic [15:0]      token_start;
      logic [LEN_W-1:0] token_length;
      logic [1:0]       fault;
      logic             final_of_run;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/symbol_language_tokenizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  slt_pkg::req_type (code_point, end_of_text)
// rsp       out        rsp_valid/rsp_stall  slt_pkg::rsp_type (kind, start, length, fault, final)
//
// One code point per cycle is taken while the result queue has room for two
// tokens; the lexer step is combinational between the input register and the
// queue, which holds the tokens on their way to rsp.
// An item that yields two tokens takes two rsp transfers; the 4-entry queue sets
// how long the block runs ahead of a stalled result side.
// Reset is synchronous: lexer idle, position zero, queue empty.
// end_of_text flushes any open token and restarts positions at zero.

`include "symbol_language_tokenizer_macros.svh"

module symbol_language_tokenizer (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire slt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output slt_pkg::rsp_type  rsp_payload
);

   // ---------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------
   logic               in_valid_ff, in_valid_in;
   slt_pkg::req_type   in_data_ff;
   logic               room;   // queue can take two tokens
   logic               fire;   // item in the input register is processed

   logic [slt_pkg::CNT_W-1:0] count_ff, count_in;

   assign room      = (count_ff <= slt_pkg::CNT_W'(slt_pkg::FIFO_DEPTH - 2));
   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_payload;
      end
   end

   // ---------------------------------------------------------------------
   // Lexer state
   // ---------------------------------------------------------------------
   slt_pkg::mode_type              mode_ff, mode_in;
   logic [slt_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [slt_pkg::POS_W-1:0]      start_ff, start_in;
   logic [slt_pkg::LEN_W-1:0]      len_ff, len_in;

   function automatic logic [slt_pkg::POS_W-1:0] next_pos(input logic [slt_pkg::POS_W-1:0] p);
      logic [slt_pkg::POS_W-1:0] r;
      if (p == slt_pkg::POS_W'(slt_pkg::MAX_TEXT - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   function automatic slt_pkg::rsp_type make_token(
      input logic [3:0]                 kind,
      input logic [slt_pkg::POS_W-1:0]  start,
      input logic [slt_pkg::LEN_W-1:0]  len,
      input logic [1:0]                 flt
   );
      slt_pkg::rsp_type t;
      t.token_kind   = kind;
      t.token_start  = 16'(start);
      t.token_length = len;
      t.fault        = flt;
      t.final_of_run = 1'b0;
      return t;
   endfunction

   // Character classes, all parallel compares.
   logic [20:0] cp;
   logic        eot;
   logic        is_letter, is_digit, is_sym, is_listed;
   logic [slt_pkg::NUM_LISTED-1:0] listed_hit;

   assign cp  = in_data_ff.code_point;
   assign eot = in_data_ff.end_of_text;

   always_comb begin
      for (int i = 0; i < slt_pkg::NUM_LISTED; i++) begin
         listed_hit[i] = (cp == slt_pkg::LISTED_SYMBOLS[i]);
      end
   end

   assign is_listed = |listed_hit;
   assign is_sym    = ((cp >= slt_pkg::CP_MATH_LO) && (cp <= slt_pkg::CP_MATH_HI))
                   || ((cp >= slt_pkg::CP_APL_LO) && (cp <= slt_pkg::CP_APL_HI))
                   || is_listed;
   assign is_letter = ((cp >= 21'h61) && (cp <= 21'h7A)) || ((cp >= 21'h41) && (cp <= 21'h5A));
   assign is_digit  = (cp >= 21'h30) && (cp <= 21'h39);

   // What a character does when it opens a new token.
   slt_pkg::mode_type          bg_mode;
   logic                       bg_set;
   logic [slt_pkg::POS_W-1:0]  bg_start;
   logic [slt_pkg::LEN_W-1:0]  bg_len;
   logic                       bg_emit;
   logic [3:0]                 bg_kind;

   always_comb begin
      bg_mode  = slt_pkg::MODE_IDLE;
      bg_set   = 1'b0;
      bg_start = pos_ff;
      bg_len   = slt_pkg::LEN_W'(1);
      bg_emit  = 1'b0;
      bg_kind  = slt_pkg::KIND_UNKNOWN;
      // jot wins over the APL range
      priority if ((cp == slt_pkg::CP_SPACE) || (cp == slt_pkg::CP_NEWLINE)) begin
         bg_mode = slt_pkg::MODE_IDLE;
      end else if (cp == slt_pkg::CP_JOT) begin
         bg_mode = slt_pkg::MODE_COMMENT;
         bg_set  = 1'b1;
      end else if (is_sym) begin
         bg_emit = 1'b1;
         bg_kind = slt_pkg::KIND_ATOM;
      end else if (is_letter) begin
         bg_mode = slt_pkg::MODE_ATOM;
         bg_set  = 1'b1;
      end else if (is_digit) begin
         bg_mode = slt_pkg::MODE_NUMBER;
         bg_set  = 1'b1;
      end else if (cp == slt_pkg::CP_SQUOTE) begin
         bg_mode  = slt_pkg::MODE_CHAR_BODY;
         bg_set   = 1'b1;
         bg_start = next_pos(pos_ff);
         bg_len   = '0;
      end else if (cp == slt_pkg::CP_DQUOTE) begin
         bg_mode  = slt_pkg::MODE_STRING;
         bg_set   = 1'b1;
         bg_start = next_pos(pos_ff);
         bg_len   = '0;
      end else if (cp == slt_pkg::CP_LBRACE) begin
         bg_emit = 1'b1;
         bg_kind = slt_pkg::KIND_LBRACE;
      end else if (cp == slt_pkg::CP_RBRACE) begin
         bg_emit = 1'b1;
         bg_kind = slt_pkg::KIND_RBRACE;
      end else if (cp == slt_pkg::CP_ARROW) begin
         bg_emit = 1'b1;
         bg_kind = slt_pkg::KIND_ARROW;
      end else begin
         bg_emit = 1'b1;
         bg_kind = slt_pkg::KIND_UNKNOWN;
      end
   end

   // Lexer step. Tokens come from three places, in this order: the token
   // closed by the current mode, the one-rune token opened by the delimiter,
   // and the flush at end of text. At most two of them fire together.
   logic                       len_sat_grow_ok;
   logic [slt_pkg::LEN_W-1:0]  len_grow;
   logic                       open_new;
   slt_pkg::mode_type          mode_mid;
   logic [slt_pkg::POS_W-1:0]  start_mid;
   logic [slt_pkg::LEN_W-1:0]  len_mid;
   logic                       cand0_vld, cand1_vld, cand2_vld;
   slt_pkg::rsp_type           cand0, cand1, cand2;

   assign len_sat_grow_ok = (len_ff != slt_pkg::LEN_MAX);
   assign len_grow        = len_sat_grow_ok ? (len_ff + 1'b1) : len_ff;

   always_comb begin
      mode_mid  = mode_ff;
      start_mid = start_ff;
      len_mid   = len_ff;
      open_new  = 1'b0;
      cand0_vld = 1'b0;
      cand0     = '0;
      cand1_vld = 1'b0;
      cand1     = '0;
      cand2_vld = 1'b0;
      cand2     = '0;

      unique case (mode_ff)
         slt_pkg::MODE_ATOM: begin
            if (is_letter) begin
               len_mid = len_grow;
            end else begin
               cand0_vld = 1'b1;
               cand0     = make_token(slt_pkg::KIND_ATOM, start_ff, len_ff, slt_pkg::FAULT_NONE);
               open_new  = 1'b1;
            end
         end
         slt_pkg::MODE_NUMBER: begin
            if (is_digit) begin
               len_mid = len_grow;
            end else begin
               cand0_vld = 1'b1;
               cand0     = make_token(slt_pkg::KIND_NUMBER, start_ff, len_ff,
                                      slt_pkg::FAULT_NONE);
               open_new  = 1'b1;
            end
         end
         slt_pkg::MODE_STRING: begin
            if (cp == slt_pkg::CP_DQUOTE) begin
               cand0_vld = 1'b1;
               cand0     = make_token(slt_pkg::KIND_STRING, start_ff, len_ff,
                                      slt_pkg::FAULT_NONE);
               mode_mid  = slt_pkg::MODE_IDLE;
            end else begin
               len_mid = len_grow;
            end
         end
         slt_pkg::MODE_CHAR_BODY: begin
            // body taken as is, even a quote
            mode_mid = slt_pkg::MODE_CHAR_CLOSE;
            len_mid  = slt_pkg::LEN_W'(1);
         end
         slt_pkg::MODE_CHAR_CLOSE: begin
            cand0_vld = 1'b1;
            cand0     = make_token(slt_pkg::KIND_CHAR, start_ff, slt_pkg::LEN_W'(1),
                                   (cp == slt_pkg::CP_SQUOTE) ? slt_pkg::FAULT_NONE
                                                              : slt_pkg::FAULT_BADCHAR);
            mode_mid  = slt_pkg::MODE_IDLE;
         end
         slt_pkg::MODE_COMMENT: begin
            // newline closes the comment and is consumed
            if (cp == slt_pkg::CP_NEWLINE) begin
               cand0_vld = 1'b1;
               cand0     = make_token(slt_pkg::KIND_COMMENT, start_ff, len_ff,
                                      slt_pkg::FAULT_NONE);
               mode_mid  = slt_pkg::MODE_IDLE;
            end else begin
               len_mid = len_grow;
            end
         end
         default: begin
            open_new = 1'b1;
         end
      endcase

      if (open_new) begin
         mode_mid  = bg_mode;
         if (bg_set) begin
            start_mid = bg_start;
            len_mid   = bg_len;
         end
         cand1_vld = bg_emit;
         cand1     = make_token(bg_kind, pos_ff, slt_pkg::LEN_W'(1), slt_pkg::FAULT_NONE);
      end

      // end of text: flush whatever is open
      if (eot) begin
         unique case (mode_mid)
            slt_pkg::MODE_ATOM: begin
               cand2_vld = 1'b1;
               cand2 = make_token(slt_pkg::KIND_ATOM, start_mid, len_mid, slt_pkg::FAULT_NONE);
            end
            slt_pkg::MODE_NUMBER: begin
               cand2_vld = 1'b1;
               cand2 = make_token(slt_pkg::KIND_NUMBER, start_mid, len_mid,
                                  slt_pkg::FAULT_NONE);
            end
            slt_pkg::MODE_STRING: begin
               cand2_vld = 1'b1;
               cand2 = make_token(slt_pkg::KIND_STRING, start_mid, len_mid,
                                  slt_pkg::FAULT_UNTERM);
            end
            slt_pkg::MODE_CHAR_BODY: begin
               cand2_vld = 1'b1;
               cand2 = make_token(slt_pkg::KIND_CHAR, start_mid, '0, slt_pkg::FAULT_UNTERM);
            end
            slt_pkg::MODE_CHAR_CLOSE: begin
               cand2_vld = 1'b1;
               cand2 = make_token(slt_pkg::KIND_CHAR, start_mid, slt_pkg::LEN_W'(1),
                                  slt_pkg::FAULT_UNTERM);
            end
            slt_pkg::MODE_COMMENT: begin
               cand2_vld = 1'b1;
               cand2 = make_token(slt_pkg::KIND_COMMENT, start_mid, len_mid,
                                  slt_pkg::FAULT_UNTERM);
            end
            default: begin
               cand2_vld = 1'b0;
            end
         endcase
      end
   end

   // End of text returns the lexer to its reset state.
   always_comb begin
      if (eot) begin
         mode_in  = slt_pkg::MODE_IDLE;
         pos_in   = '0;
         start_in = '0;
         len_in   = '0;
      end else begin
         mode_in  = mode_mid;
         pos_in   = next_pos(pos_ff);
         start_in = start_mid;
         len_in   = len_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= slt_pkg::MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
      end
   end

   // Pack the candidates into at most two queue writes.
   slt_pkg::rsp_type tok0, tok1;
   logic [1:0]       tok_count;

   always_comb begin
      tok_count = 2'(cand0_vld) + 2'(cand1_vld) + 2'(cand2_vld);
      if (cand0_vld) begin
         tok0 = cand0;
         tok1 = cand1_vld ? cand1 : cand2;
      end else begin
         tok0 = cand1_vld ? cand1 : cand2;
         tok1 = cand2;
      end
      tok0.final_of_run = (tok_count == 2'd1);
      tok1.final_of_run = 1'b1;
   end

   // ---------------------------------------------------------------------
   // Result queue
   // ---------------------------------------------------------------------
   slt_pkg::rsp_type            fifo_ff [slt_pkg::FIFO_DEPTH];
   logic [slt_pkg::PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [slt_pkg::PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [slt_pkg::PTR_W-1:0]   wr_ptr_next;
   logic [1:0]                  push_count;
   logic                        pop;

   assign push_count  = fire ? tok_count : 2'd0;
   assign pop         = rsp_valid && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;
   assign wr_ptr_in   = wr_ptr_ff + slt_pkg::PTR_W'(push_count);
   assign rd_ptr_in   = rd_ptr_ff + slt_pkg::PTR_W'(pop);
   assign count_in    = count_ff + slt_pkg::CNT_W'(push_count) - slt_pkg::CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= tok0;
      end
      if (push_count == 2'd2) begin
         fifo_ff[wr_ptr_next] <= tok1;
      end
   end

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = fifo_ff[rd_ptr_ff];

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `SLT_ASSERT_IMPLY(a_queue_bound, clock, reset, 1'b1, count_ff <= slt_pkg::CNT_W'(slt_pkg::FIFO_DEPTH))
   `SLT_ASSERT_IMPLY(a_push_has_room, clock, reset, push_count != 2'd0, count_ff <= slt_pkg::CNT_W'(slt_pkg::FIFO_DEPTH - 2))
   `SLT_ASSERT_NEXT(a_eot_restarts, clock, reset, fire && in_data_ff.end_of_text, (mode_ff == slt_pkg::MODE_IDLE) && (pos_ff == '0))

endmodule

`default_nettype wire

[bench/tb_symbol_language_tokenizer.sv]
`timescale 1ns / 1ps

module tb_symbol_language_tokenizer;

   // Cycles in a row with no transaction on either side before we give up.
   localparam int STUCK_LIMIT = 2000;
   // Slack allowed after the last token.
   localparam int DRAIN_CYCLES = 20;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   slt_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   slt_pkg::rsp_type rsp_payload;

   symbol_language_tokenizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Listed one-rune symbols, outside the math and APL ranges.
   logic [20:0] listed_cp [22] = '{
      21'h0007C, 21'h0007E, 21'h000AF, 21'h000D7, 21'h000F7, 21'h02218,
      21'h02223, 21'h0223C, 21'h02260, 21'h02264, 21'h02265, 21'h022C6,
      21'h02227, 21'h02228, 21'h02229, 21'h0222A, 21'h02308, 21'h0230A,
      21'h022A4, 21'h022A5, 21'h02282, 21'h02283
   };

   // ------------------------------------------------------------------
   // Lexer prediction: same state as the block, updated per accepted
   // transaction. Positions count modulo MAX_TEXT; tokens carry 16 bits.
   // ------------------------------------------------------------------
   slt_pkg::mode_type           lex_mode  = slt_pkg::MODE_IDLE;
   logic [slt_pkg::POS_W-1:0]   lex_pos   = '0;
   logic [slt_pkg::POS_W-1:0]   tok_start = '0;
   logic [15:0]                 tok_len   = '0;

   slt_pkg::rsp_type tokens_due[$];     // predicted tokens not yet seen on rsp
   slt_pkg::rsp_type step_tokens[$];    // tokens caused by the current character
   slt_pkg::req_type chars_to_send[$];  // characters waiting for the driver

   int  mismatches = 0;
   int  tokens_seen = 0;
   int  cycle_no = 0;
   int  stuck_cycles = 0;
   logic req_taken = 1'b0;
   bit  random_ends = 1'b0;

   function automatic bit is_letter(logic [20:0] cp);
      return (cp >= 21'h61 && cp <= 21'h7A) || (cp >= 21'h41 && cp <= 21'h5A);
   endfunction

   function automatic bit is_digit(logic [20:0] cp);
      return cp >= 21'h30 && cp <= 21'h39;
   endfunction

   function automatic bit is_symbol(logic [20:0] cp);
      if (cp >= slt_pkg::CP_MATH_LO && cp <= slt_pkg::CP_MATH_HI) return 1'b1;
      if (cp >= slt_pkg::CP_APL_LO && cp <= slt_pkg::CP_APL_HI) return 1'b1;
      for (int k = 0; k < 22; k++)
         if (listed_cp[k] == cp) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [slt_pkg::POS_W-1:0] step_pos(logic [slt_pkg::POS_W-1:0] p);
      return (p == slt_pkg::POS_W'(slt_pkg::MAX_TEXT - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic void add_token(logic [3:0] kind, logic [slt_pkg::POS_W-1:0] start,
                                     logic [15:0] len, logic [1:0] fault);
      slt_pkg::rsp_type t;
      t.token_kind   = kind;
      t.token_start  = 16'(start);
      t.token_length = len;
      t.fault        = fault;
      t.final_of_run = 1'b0;
      step_tokens.push_back(t);
   endfunction

   // Length counter saturates instead of wrapping.
   function automatic void extend_run();
      if (tok_len != slt_pkg::LEN_MAX) tok_len = tok_len + 16'd1;
   endfunction

   // Character seen between tokens (or the delimiter ending an atom/number).
   function automatic void open_token(logic [20:0] cp, logic [slt_pkg::POS_W-1:0] at);
      lex_mode = slt_pkg::MODE_IDLE;
      if (cp == slt_pkg::CP_SPACE || cp == slt_pkg::CP_NEWLINE) return;
      // jot wins over the APL range it sits in
      if (cp == slt_pkg::CP_JOT) begin
         lex_mode = slt_pkg::MODE_COMMENT;
         tok_start = at;
         tok_len = 16'd1;
      end else if (is_symbol(cp)) begin
         add_token(slt_pkg::KIND_ATOM, at, 16'd1, slt_pkg::FAULT_NONE);
      end else if (is_letter(cp)) begin
         lex_mode = slt_pkg::MODE_ATOM;
         tok_start = at;
         tok_len = 16'd1;
      end else if (is_digit(cp)) begin
         lex_mode = slt_pkg::MODE_NUMBER;
         tok_start = at;
         tok_len = 16'd1;
      end else if (cp == slt_pkg::CP_SQUOTE) begin
         lex_mode = slt_pkg::MODE_CHAR_BODY;
         tok_start = step_pos(at);
         tok_len = '0;
      end else if (cp == slt_pkg::CP_DQUOTE) begin
         lex_mode = slt_pkg::MODE_STRING;
         tok_start = step_pos(at);
         tok_len = '0;
      end else if (cp == slt_pkg::CP_LBRACE) begin
         add_token(slt_pkg::KIND_LBRACE, at, 16'd1, slt_pkg::FAULT_NONE);
      end else if (cp == slt_pkg::CP_RBRACE) begin
         add_token(slt_pkg::KIND_RBRACE, at, 16'd1, slt_pkg::FAULT_NONE);
      end else if (cp == slt_pkg::CP_ARROW) begin
         add_token(slt_pkg::KIND_ARROW, at, 16'd1, slt_pkg::FAULT_NONE);
      end else begin
         add_token(slt_pkg::KIND_UNKNOWN, at, 16'd1, slt_pkg::FAULT_NONE);
      end
   endfunction

   function automatic void lex_char(slt_pkg::req_type item);
      logic [20:0]               cp;
      logic [slt_pkg::POS_W-1:0] at;
      slt_pkg::rsp_type          last;
      cp = item.code_point;
      at = lex_pos;
      step_tokens.delete();

      case (lex_mode)
         slt_pkg::MODE_ATOM, slt_pkg::MODE_NUMBER: begin
            if (lex_mode == slt_pkg::MODE_ATOM ? is_letter(cp) : is_digit(cp)) begin
               extend_run();
            end else begin
               // delimiter closes the run and is then lexed on its own
               add_token(lex_mode == slt_pkg::MODE_ATOM ? slt_pkg::KIND_ATOM
                                                        : slt_pkg::KIND_NUMBER,
                         tok_start, tok_len, slt_pkg::FAULT_NONE);
               open_token(cp, at);
            end
         end
         slt_pkg::MODE_STRING: begin
            if (cp == slt_pkg::CP_DQUOTE) begin
               add_token(slt_pkg::KIND_STRING, tok_start, tok_len, slt_pkg::FAULT_NONE);
               lex_mode = slt_pkg::MODE_IDLE;
            end else begin
               extend_run();
            end
         end
         slt_pkg::MODE_CHAR_BODY: begin
            // body taken as is, a quote included
            lex_mode = slt_pkg::MODE_CHAR_CLOSE;
            tok_len = 16'd1;
         end
         slt_pkg::MODE_CHAR_CLOSE: begin
            // a missing closing quote still yields the char; the stray
            // character is swallowed
            add_token(slt_pkg::KIND_CHAR, tok_start, 16'd1,
                      cp == slt_pkg::CP_SQUOTE ? slt_pkg::FAULT_NONE
                                               : slt_pkg::FAULT_BADCHAR);
            lex_mode = slt_pkg::MODE_IDLE;
         end
         slt_pkg::MODE_COMMENT: begin
            if (cp == slt_pkg::CP_NEWLINE) begin
               add_token(slt_pkg::KIND_COMMENT, tok_start, tok_len, slt_pkg::FAULT_NONE);
               lex_mode = slt_pkg::MODE_IDLE;
            end else begin
               extend_run();
            end
         end
         default: open_token(cp, at);
      endcase

      lex_pos = step_pos(lex_pos);

      // End of text flushes whatever is open, then back to the reset state.
      if (item.end_of_text) begin
         case (lex_mode)
            slt_pkg::MODE_ATOM:
               add_token(slt_pkg::KIND_ATOM, tok_start, tok_len, slt_pkg::FAULT_NONE);
            slt_pkg::MODE_NUMBER:
               add_token(slt_pkg::KIND_NUMBER, tok_start, tok_len, slt_pkg::FAULT_NONE);
            slt_pkg::MODE_STRING:
               add_token(slt_pkg::KIND_STRING, tok_start, tok_len, slt_pkg::FAULT_UNTERM);
            slt_pkg::MODE_CHAR_BODY:
               add_token(slt_pkg::KIND_CHAR, tok_start, 16'd0, slt_pkg::FAULT_UNTERM);
            slt_pkg::MODE_CHAR_CLOSE:
               add_token(slt_pkg::KIND_CHAR, tok_start, 16'd1, slt_pkg::FAULT_UNTERM);
            slt_pkg::MODE_COMMENT:
               add_token(slt_pkg::KIND_COMMENT, tok_start, tok_len, slt_pkg::FAULT_UNTERM);
            default: ;
         endcase
         lex_mode  = slt_pkg::MODE_IDLE;
         lex_pos   = '0;
         tok_start = '0;
         tok_len   = '0;
      end

      if (step_tokens.size() > 0) begin
         last = step_tokens.pop_back();
         last.final_of_run = 1'b1;
         step_tokens.push_back(last);
      end
      foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: token %0d %s: got %0h, expected %0h",
               $realtime, tokens_seen, what, got, want);
      mismatches++;
   endtask

   task automatic check_token(slt_pkg::rsp_type got);
      slt_pkg::rsp_type want;
      if (tokens_due.size() == 0) begin
         report_mismatch("not expected, kind", got.token_kind, 0);
      end else begin
         want = tokens_due.pop_front();
         if (got.token_kind !== want.token_kind)
            report_mismatch("kind", got.token_kind, want.token_kind);
         if (got.token_start !== want.token_start)
            report_mismatch("start", got.token_start, want.token_start);
         if (got.token_length !== want.token_length)
            report_mismatch("length", got.token_length, want.token_length);
         if (got.fault !== want.fault)
            report_mismatch("fault", got.fault, want.fault);
         if (got.final_of_run !== want.final_of_run)
            report_mismatch("final flag", got.final_of_run, want.final_of_run);
      end
      tokens_seen++;
   endtask

   // Monitor: sample both channels at the rising edge, predict, compare,
   // and keep the watchdog.
   always @(posedge clock) begin : monitor
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         cycle_no++;
         if (req_valid && !req_stall) lex_char(req_payload);
         if (rsp_valid && !rsp_stall) check_token(rsp_payload);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Driver: changes inputs on the falling edge. About 13% idle on each
   // side, except in the quiet stretch, where neither side idles.
   always @(negedge clock) begin : driver
      bit quiet;
      quiet = (cycle_no % 1000) >= 600;
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (chars_to_send.size() > 0 && (quiet || $urandom_range(99) >= 13)) begin
               req_payload <= chars_to_send.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= !quiet && ($urandom_range(99) < 13);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic push_char(logic [20:0] cp, logic eot = 1'b0);
      slt_pkg::req_type r;
      r.code_point  = cp;
      r.end_of_text = eot | (random_ends && $urandom_range(29) == 0);
      chars_to_send.push_back(r);
   endtask

   // Mostly ASCII, some BMP around the symbol blocks, some anything.
   function automatic logic [20:0] any_char();
      case ($urandom_range(3))
         0, 1:    return 21'($urandom_range(21'h7E, 21'h20));
         2:       return 21'($urandom_range(21'h2400));
         default: return 21'($urandom_range(21'h1FFFFF));
      endcase
   endfunction

   function automatic logic [20:0] rand_letter();
      return 21'($urandom_range(1) ? 21'h61 : 21'h41) + 21'($urandom_range(25));
   endfunction

   // One well-formed token (with random content), a separator, or noise.
   task automatic queue_phrase();
      int pick;
      int n;
      logic [20:0] cp;
      pick = $urandom_range(99);
      if (pick < 20) begin
         n = $urandom_range(6, 1);
         repeat (n) push_char(rand_letter());
      end else if (pick < 32) begin
         n = $urandom_range(5, 1);
         repeat (n) push_char(21'h30 + 21'($urandom_range(9)));
      end else if (pick < 42) begin
         push_char(slt_pkg::CP_DQUOTE);
         n = $urandom_range(6);
         repeat (n) begin
            cp = any_char();
            push_char(cp == slt_pkg::CP_DQUOTE ? 21'h78 : cp);
         end
         push_char(slt_pkg::CP_DQUOTE);
      end else if (pick < 50) begin
         push_char(slt_pkg::CP_SQUOTE);
         push_char(any_char());
         push_char(slt_pkg::CP_SQUOTE);
      end else if (pick < 58) begin
         push_char(slt_pkg::CP_JOT);
         n = $urandom_range(6);
         repeat (n) begin
            cp = any_char();
            push_char(cp == slt_pkg::CP_NEWLINE ? 21'h2A : cp);
         end
         push_char(slt_pkg::CP_NEWLINE);
      end else if (pick < 68) begin
         case ($urandom_range(2))
            0:       push_char(21'($urandom_range(slt_pkg::CP_MATH_HI, slt_pkg::CP_MATH_LO)));
            1:       push_char(21'($urandom_range(slt_pkg::CP_APL_HI, slt_pkg::CP_APL_LO)));
            default: push_char(listed_cp[$urandom_range(21)]);
         endcase
      end else if (pick < 74) begin
         case ($urandom_range(2))
            0:       push_char(slt_pkg::CP_LBRACE);
            1:       push_char(slt_pkg::CP_RBRACE);
            default: push_char(slt_pkg::CP_ARROW);
         endcase
      end else if (pick < 86) begin
         push_char($urandom_range(1) ? slt_pkg::CP_SPACE : slt_pkg::CP_NEWLINE);
      end else if (pick < 92) begin
         push_char(21'($urandom_range(21'h1FFFFF)));
      end else if (pick < 96) begin
         // char literal with the closing quote missing
         push_char(slt_pkg::CP_SQUOTE);
         push_char(any_char());
         cp = any_char();
         push_char(cp == slt_pkg::CP_SQUOTE ? 21'h40 : cp);
      end else begin
         push_char(any_char());
      end
   endtask

   initial begin : stimulus
      int base;

      // Directed: run delimiters, the symbol range edges, comment, char
      // literal holding a quote, bad char, empty string, top code point,
      // and unterminated string and char at end of text.
      push_char(21'h41);                       // 'A'
      push_char(21'h7A);                       // 'z'
      push_char(21'h30);                       // digit ends atom, starts number
      push_char(21'h39);
      push_char(slt_pkg::CP_LBRACE);           // number and lbrace from one transaction
      push_char(slt_pkg::CP_RBRACE);
      push_char(slt_pkg::CP_ARROW);
      push_char(slt_pkg::CP_MATH_LO);
      push_char(slt_pkg::CP_MATH_HI);
      push_char(slt_pkg::CP_APL_LO);
      push_char(slt_pkg::CP_APL_HI);
      push_char(slt_pkg::CP_JOT);
      push_char(21'h78);
      push_char(slt_pkg::CP_NEWLINE);
      push_char(slt_pkg::CP_SQUOTE);
      push_char(slt_pkg::CP_SQUOTE);
      push_char(slt_pkg::CP_SQUOTE);
      push_char(slt_pkg::CP_SQUOTE);
      push_char(21'h61);
      push_char(21'h62);                       // bad char, 'b' swallowed
      push_char(slt_pkg::CP_DQUOTE);
      push_char(slt_pkg::CP_DQUOTE);
      push_char(21'h1FFFFF);
      push_char(slt_pkg::CP_DQUOTE, 1'b1);     // open string at end of text
      push_char(slt_pkg::CP_SQUOTE, 1'b1);     // char with no body at end of text

      // Random part: token sequences with end of text landing anywhere.
      random_ends = 1'b1;
      base = chars_to_send.size();
      while (chars_to_send.size() < base + 860) queue_phrase();
      random_ends = 1'b0;
      push_char(slt_pkg::CP_SPACE, 1'b1);

      push_char(slt_pkg::CP_JOT);
      push_char(21'h63, 1'b1);                 // open comment at end of text

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Everything sent and every token back, then a short drain.
      while (chars_to_send.size() != 0 || req_valid || tokens_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0 && tokens_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
